>>> hw/rtl/bllca_pkg.sv
`timescale 1ns / 1ps
// Package for the binary-lifting LCA engine: sizes, opcodes, FSM states,
// controller/datapath command and status structs, address helpers. No dependencies.
package bllca_pkg;

    localparam int MAX_NODES   = 1024;
    localparam int JUMP_LEVELS = 10;
    localparam int NODE_W      = 10;
    localparam int OP_W        = 2;

    localparam int IDX_W    = $clog2(MAX_NODES);
    localparam int LVL_W    = $clog2(JUMP_LEVELS);
    localparam int JT_AW    = IDX_W + LVL_W;
    localparam int JT_DEPTH = MAX_NODES << LVL_W;

    typedef logic [NODE_W-1:0] node_t;
    typedef logic [LVL_W-1:0]  lvl_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [JT_AW-1:0]  jt_addr_t;

    localparam node_t DEPTH_MAX = '1;
    localparam lvl_t  LVL_TOP   = LVL_W'(JUMP_LEVELS - 1);

    typedef enum logic [OP_W-1:0] {
        OP_LOAD = 2'd0,
        OP_LCA  = 2'd1,
        OP_KTH  = 2'd2
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_LD_DWR,
        S_LD_RD,
        S_LD_WR,
        S_Q_DCHK,
        S_CL_CHK,
        S_CL_WAIT,
        S_CL_END,
        S_LF_RD,
        S_LF_CMP,
        S_FIN_RD,
        S_FIN_WAIT,
        S_POST
    } state_t;

    typedef struct packed {
        logic capture;   // latch the input transaction
        logic dep_par;   // depth port A reads the parent instead of node_a
        logic jt_we;     // write one jump-table entry of node_a
        logic jt_lvl0;   // entry is level 0 (parent) instead of lvl+1
        logic dep_we;    // write node_a depth
        logic u_par;     // u <= parent
        logic u_eff;     // u <= jump-table read A
        logic q_kth;     // k-th ancestor setup
        logic q_lca;     // LCA setup, deeper node into u
        logic k_sub;     // k -= 2^lvl
        logic lift;      // LCA lift step
        logic lvl_clr;
        logic lvl_top;
        logic lvl_inc;
        logic lvl_dec;
        logic res_zero;
        logic res_u;
        logic res_eff;
        logic post;      // move result into output register
    } ctl_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic a_real;
        logic lvl_zero;
        logic lvl_last;
        logic k_take;
        logic k_gt_d;
        logic u_eq_v;
        logic out_free;
    } ctl_status_t;

    // Node 0 and indexes beyond the table act as the all-zero sentinel.
    function automatic logic is_real(input node_t n);
        return (n != '0) && (32'(n) < MAX_NODES);
    endfunction

    function automatic idx_t node_idx(input node_t n);
        return IDX_W'(n);
    endfunction

    function automatic jt_addr_t jt_addr(input node_t n, input lvl_t l);
        return {node_idx(n), l};
    endfunction

endpackage

>>> hw/rtl/bllca_in_if.sv
`timescale 1ns / 1ps
// Input channel interface: valid/ready plus one load or query transaction.
// Depends on bllca_pkg for field widths.
interface bllca_in_if;
    logic                        valid;
    logic                        ready;
    logic [bllca_pkg::OP_W-1:0]   op;
    logic [bllca_pkg::NODE_W-1:0] node_a;
    logic [bllca_pkg::NODE_W-1:0] node_b;
    logic [bllca_pkg::NODE_W-1:0] parent_node;
    logic [bllca_pkg::NODE_W-1:0] steps;

    modport source (output valid, op, node_a, node_b, parent_node, steps, input ready);
    modport sink   (input valid, op, node_a, node_b, parent_node, steps, output ready);
endinterface

>>> hw/rtl/bllca_out_if.sv
`timescale 1ns / 1ps
// Output channel interface: valid/ready plus one query result transaction.
// Depends on bllca_pkg for field widths.
interface bllca_out_if;
    logic                        valid;
    logic                        ready;
    logic [bllca_pkg::NODE_W-1:0] result_node;

    modport source (output valid, result_node, input ready);
    modport sink   (input valid, result_node, output ready);
endinterface

>>> hw/rtl/bllca_ram.sv
`timescale 1ns / 1ps
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module bllca_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] ra_addr,
    output logic [WIDTH-1:0]         ra_data,
    input  logic [$clog2(DEPTH)-1:0] rb_addr,
    output logic [WIDTH-1:0]         rb_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        ra_data <= mem[ra_addr];
        rb_data <= mem[rb_addr];
    end

endmodule

>>> hw/rtl/bllca_datapath.sv
`timescale 1ns / 1ps
// Datapath: transaction registers, walk registers, jump-table and depth RAMs,
// output register. Depends on bllca_pkg and bllca_ram.
module bllca_datapath (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [bllca_pkg::OP_W-1:0] in_op,
    input  bllca_pkg::node_t        in_node_a,
    input  bllca_pkg::node_t        in_node_b,
    input  bllca_pkg::node_t        in_parent,
    input  bllca_pkg::node_t        in_steps,
    input  logic                    out_ready,
    output logic                    out_valid,
    output bllca_pkg::node_t        out_node,
    input  bllca_pkg::ctl_cmd_t     cmd,
    output bllca_pkg::ctl_status_t  status
);
    import bllca_pkg::*;

    logic [OP_W-1:0] op_reg, op_next;
    node_t a_reg, a_next, b_reg, b_next, par_reg, par_next, k_reg, k_next;
    node_t u_reg, u_next, v_reg, v_next, res_reg, res_next, out_reg, out_next;
    lvl_t  lvl_reg, lvl_next;
    logic  out_valid_reg, out_valid_next;

    // sentinel flags, aligned with the registered RAM read data
    logic  za_reg, zb_reg, dza_reg, dzb_reg;

    node_t jt_ra_data, jt_rb_data, dp_ra_data, dp_rb_data;
    node_t jt_a, jt_b, dep_a, dep_b;
    node_t dep_rd_node, jt_wdata, dep_wdata, span;
    lvl_t  lvl_plus1, jt_wlvl;

    assign jt_a  = za_reg  ? '0 : jt_ra_data;
    assign jt_b  = zb_reg  ? '0 : jt_rb_data;
    assign dep_a = dza_reg ? '0 : dp_ra_data;
    assign dep_b = dzb_reg ? '0 : dp_rb_data;

    assign dep_rd_node = cmd.dep_par ? par_reg : a_reg;
    assign lvl_plus1   = lvl_reg + LVL_W'(1);
    assign jt_wlvl     = cmd.jt_lvl0 ? '0 : lvl_plus1;
    assign jt_wdata    = cmd.jt_lvl0 ? par_reg : jt_a;
    assign span        = NODE_W'(1) << lvl_reg;

    // parent depth + 1, saturating; roots sit at depth 0
    always_comb
    begin
        if (par_reg == '0)
        begin
            dep_wdata = '0;
        end
        else if (dep_a == DEPTH_MAX)
        begin
            dep_wdata = DEPTH_MAX;
        end
        else
        begin
            dep_wdata = dep_a + NODE_W'(1);
        end
    end

    bllca_ram #(
        .WIDTH (NODE_W),
        .DEPTH (JT_DEPTH)
    ) u_jt_ram (
        .clk     (clk),
        .we      (cmd.jt_we),
        .waddr   (jt_addr(a_reg, jt_wlvl)),
        .wdata   (jt_wdata),
        .ra_addr (jt_addr(u_reg, lvl_reg)),
        .ra_data (jt_ra_data),
        .rb_addr (jt_addr(v_reg, lvl_reg)),
        .rb_data (jt_rb_data)
    );

    bllca_ram #(
        .WIDTH (NODE_W),
        .DEPTH (MAX_NODES)
    ) u_depth_ram (
        .clk     (clk),
        .we      (cmd.dep_we),
        .waddr   (node_idx(a_reg)),
        .wdata   (dep_wdata),
        .ra_addr (node_idx(dep_rd_node)),
        .ra_data (dp_ra_data),
        .rb_addr (node_idx(b_reg)),
        .rb_data (dp_rb_data)
    );

    always_comb
    begin
        op_next        = op_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        par_next       = par_reg;
        k_next         = k_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        lvl_next       = lvl_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (cmd.capture)
        begin
            op_next  = in_op;
            a_next   = in_node_a;
            b_next   = in_node_b;
            par_next = in_parent;
            k_next   = in_steps;
        end

        if (cmd.u_par)
        begin
            u_next = par_reg;
        end
        if (cmd.u_eff)
        begin
            u_next = jt_a;
        end
        if (cmd.q_kth)
        begin
            u_next = a_reg;
        end
        if (cmd.q_lca)
        begin
            if (dep_a < dep_b)
            begin
                u_next = b_reg;
                v_next = a_reg;
                k_next = dep_b - dep_a;
            end
            else
            begin
                u_next = a_reg;
                v_next = b_reg;
                k_next = dep_a - dep_b;
            end
        end
        if (cmd.k_sub)
        begin
            k_next = k_reg - span;
        end
        if (cmd.lift && (jt_a != jt_b))
        begin
            u_next = jt_a;
            v_next = jt_b;
        end

        if (cmd.lvl_clr)
        begin
            lvl_next = '0;
        end
        if (cmd.lvl_top)
        begin
            lvl_next = LVL_TOP;
        end
        if (cmd.lvl_inc)
        begin
            lvl_next = lvl_plus1;
        end
        if (cmd.lvl_dec)
        begin
            lvl_next = lvl_reg - LVL_W'(1);
        end

        if (cmd.res_zero)
        begin
            res_next = '0;
        end
        if (cmd.res_u)
        begin
            res_next = u_reg;
        end
        if (cmd.res_eff)
        begin
            res_next = jt_a;
        end

        if (cmd.post)
        begin
            out_next       = res_reg;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        par_reg <= par_next;
        k_reg   <= k_next;
        u_reg   <= u_next;
        v_reg   <= v_next;
        lvl_reg <= lvl_next;
        res_reg <= res_next;
        out_reg <= out_next;
        za_reg  <= !is_real(u_reg);
        zb_reg  <= !is_real(v_reg);
        dza_reg <= !is_real(dep_rd_node);
        dzb_reg <= !is_real(b_reg);
    end

    assign out_valid = out_valid_reg;
    assign out_node  = out_reg;

    assign status.op       = op_reg;
    assign status.a_real   = is_real(a_reg);
    assign status.lvl_zero = (lvl_reg == '0);
    assign status.lvl_last = (lvl_plus1 == LVL_TOP);
    assign status.k_take   = ((k_reg >> lvl_reg) != '0);
    assign status.k_gt_d   = (k_reg > dep_a);
    assign status.u_eq_v   = (u_reg == v_reg);
    assign status.out_free = !out_valid_reg || out_ready;

endmodule

>>> hw/rtl/bllca_controller.sv
`timescale 1ns / 1ps
// Controller FSM: sequences loads, climbs and LCA lifts through the datapath.
// Depends on bllca_pkg.
module bllca_controller (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  bllca_pkg::ctl_status_t status,
    output bllca_pkg::ctl_cmd_t    cmd
);
    import bllca_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (status.op)
                    OP_LOAD: state_next = status.a_real ? S_LD_DWR : S_IDLE;
                    OP_LCA:  state_next = S_Q_DCHK;
                    OP_KTH:  state_next = S_Q_DCHK;
                    default: state_next = S_IDLE;
                endcase
            end
            S_LD_DWR: state_next = S_LD_RD;
            S_LD_RD:  state_next = S_LD_WR;
            S_LD_WR:  state_next = status.lvl_last ? S_IDLE : S_LD_RD;
            S_Q_DCHK:
            begin
                if ((status.op == OP_KTH) && status.k_gt_d)
                begin
                    state_next = S_POST;
                end
                else
                begin
                    state_next = S_CL_CHK;
                end
            end
            S_CL_CHK:
            begin
                if (status.k_take)
                begin
                    state_next = S_CL_WAIT;
                end
                else if (status.lvl_zero)
                begin
                    state_next = S_CL_END;
                end
            end
            S_CL_WAIT: state_next = status.lvl_zero ? S_CL_END : S_CL_CHK;
            S_CL_END:
            begin
                if ((status.op == OP_KTH) || status.u_eq_v)
                begin
                    state_next = S_POST;
                end
                else
                begin
                    state_next = S_LF_RD;
                end
            end
            S_LF_RD:    state_next = S_LF_CMP;
            S_LF_CMP:   state_next = status.lvl_zero ? S_FIN_RD : S_LF_RD;
            S_FIN_RD:   state_next = S_FIN_WAIT;
            S_FIN_WAIT: state_next = S_POST;
            S_POST:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_DECODE:
            begin
                cmd.dep_par = (status.op == OP_LOAD);
            end
            S_LD_DWR:
            begin
                cmd.jt_we   = 1'b1;
                cmd.jt_lvl0 = 1'b1;
                cmd.dep_we  = 1'b1;
                cmd.u_par   = 1'b1;
                cmd.lvl_clr = 1'b1;
            end
            S_LD_RD:
            begin
                cmd = '0;
            end
            S_LD_WR:
            begin
                cmd.jt_we   = 1'b1;
                cmd.u_eff   = 1'b1;
                cmd.lvl_inc = !status.lvl_last;
            end
            S_Q_DCHK:
            begin
                if (status.op == OP_KTH)
                begin
                    if (status.k_gt_d)
                    begin
                        cmd.res_zero = 1'b1;
                    end
                    else
                    begin
                        cmd.q_kth   = 1'b1;
                        cmd.lvl_top = 1'b1;
                    end
                end
                else
                begin
                    cmd.q_lca   = 1'b1;
                    cmd.lvl_top = 1'b1;
                end
            end
            S_CL_CHK:
            begin
                if (status.k_take)
                begin
                    cmd.k_sub = 1'b1;
                end
                else
                begin
                    cmd.lvl_dec = !status.lvl_zero;
                end
            end
            S_CL_WAIT:
            begin
                cmd.u_eff   = 1'b1;
                cmd.lvl_dec = !status.lvl_zero;
            end
            S_CL_END:
            begin
                if ((status.op == OP_KTH) || status.u_eq_v)
                begin
                    cmd.res_u = 1'b1;
                end
                else
                begin
                    cmd.lvl_top = 1'b1;
                end
            end
            S_LF_RD:
            begin
                cmd = '0;
            end
            S_LF_CMP:
            begin
                cmd.lift    = 1'b1;
                cmd.lvl_dec = !status.lvl_zero;
            end
            S_FIN_RD:
            begin
                cmd = '0;
            end
            S_FIN_WAIT:
            begin
                cmd.res_eff = 1'b1;
            end
            S_POST:
            begin
                cmd.post = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> hw/rtl/binary_lifting_lca_engine.sv
`timescale 1ns / 1ps
// Binary-lifting LCA engine top level: controller, datapath, channel interfaces.
// A load writes level 0 from the parent, then one jump-table read and write per higher
// level; k-th ancestor posts zero without a climb if steps exceed the depth; an LCA
// climbs the deeper node, then lifts both; drops go back to idle. A full result register
// adds its wait. One transaction at a time: ready returns the cycle after the walk ends.
// Reset (async, active low) clears the FSM and output valid; RAMs are not cleared.
module binary_lifting_lca_engine (
    input logic       clk,
    input logic       rst_n,
    bllca_in_if.sink  item,
    bllca_out_if.source result
);
    import bllca_pkg::*;

    ctl_cmd_t    cmd;
    ctl_status_t status;

    // Sequencing only: every state transition is decided here, from in_valid
    // and the datapath status flags.
    bllca_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (item.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Jump table is addressed {node, level}; node 0 (and any index outside
    // the table) is forced to read zero after the RAM, so it is never stored.
    // The output register lets a result wait while the next transaction
    // is taken in.
    bllca_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_op     (item.op),
        .in_node_a (item.node_a),
        .in_node_b (item.node_b),
        .in_parent (item.parent_node),
        .in_steps  (item.steps),
        .out_ready (result.ready),
        .out_valid (result.valid),
        .out_node  (result.result_node),
        .cmd       (cmd),
        .status    (status)
    );

    // A result only appears after the controller posts one.
    a_valid_from_post: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(cmd.post))
        else $error("result valid rose without a post");

    // Once a transaction is taken, the engine is busy the next cycle.
    a_busy_after_capture: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> !item.ready)
        else $error("ready stayed high after capture");

    // Table writes never target the sentinel.
    a_no_sentinel_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.jt_we || cmd.dep_we) |-> status.a_real)
        else $error("write to sentinel node");

    // No RAM write while the engine offers ready.
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        item.ready |-> !(cmd.jt_we || cmd.dep_we))
        else $error("RAM write while idle");

endmodule

>>> tb/binary_lifting_lca_engine_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the binary-lifting LCA engine: directed table, then
// random tree builds and queries, checked against typed answers or a built-in predictor.
// Depends on bllca_pkg, bllca_in_if, bllca_out_if and binary_lifting_lca_engine.
module binary_lifting_lca_engine_test;
    import bllca_pkg::*;

    // Opcode the engine must drop without answering.
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    localparam int LONG_HOLD   = 400;        // receiver back-pressure stretch, cycles
    localparam int SETTLE      = 60;         // margin for the longest walk after accept
    localparam int DRAIN_LIMIT = 20000;
    localparam int TAIL_ITEMS  = 120;

    logic clk;
    logic rst_n;

    bllca_in_if  item_ch ();
    bllca_out_if result_ch ();

    binary_lifting_lca_engine u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    // ------------------------------------------------------------------
    // Predictor state: one row of 2^i ancestors per node plus its depth.
    // Node 0 is never written and stays all-zero, like the sentinel.
    // ------------------------------------------------------------------
    bit [NODE_W-1:0] anc_tab   [MAX_NODES][JUMP_LEVELS];
    bit [NODE_W-1:0] depth_tab [MAX_NODES];
    bit              is_loaded [MAX_NODES];
    int              loaded_ids[$];

    int answers_due[$];       // answers of accepted queries, oldest first

    int  fail_count      = 0;
    int  results_checked = 0;
    int  loads_done      = 0;
    int  lca_done        = 0;
    int  kth_done        = 0;
    int  ignored_done    = 0;
    int  deepest_seen    = 0;
    bit  quiet_tail      = 1'b0;   // no idling on either side near the end
    bit  long_hold_done  = 1'b0;
    int  src_left        = 0;
    int  src_pct         = 0;
    int  sink_left       = 0;
    int  sink_pct        = 0;

    typedef struct {
        logic [OP_W-1:0] op;
        int              a;
        int              b;
        int              par;
        int              steps;
        bit              typed;    // answer written in the row, not predicted
        int              want;
    } stim_row_t;

    // Directed part. Nodes 1023 -> 512 -> 2 hang below root 1, 3 is a sibling of
    // 512, 4 is a second root. Then a self-parent reload and a cycle (1 under 2).
    stim_row_t plan [25] = '{
        '{OP_KTH,  0,    0,    0,    0,    1'b1, 0},    // sentinel, empty engine
        '{OP_LCA,  0,    0,    0,    0,    1'b1, 0},
        '{OP_LOAD, 0,    0,    0,    0,    1'b0, 0},    // load of node 0 is dropped
        '{OP_LOAD, 1,    0,    0,    0,    1'b0, 0},    // root
        '{OP_KTH,  1,    0,    0,    0,    1'b1, 1},
        '{OP_KTH,  1,    0,    0,    1,    1'b1, 0},    // steps beyond depth
        '{OP_LOAD, 1023, 0,    1,    0,    1'b0, 0},
        '{OP_LOAD, 512,  0,    1023, 0,    1'b0, 0},
        '{OP_LOAD, 2,    0,    512,  0,    1'b0, 0},
        '{OP_KTH,  2,    0,    0,    3,    1'b1, 1},
        '{OP_KTH,  2,    0,    0,    1023, 1'b1, 0},
        '{OP_LCA,  1023, 2,    0,    0,    1'b1, 1023}, // one is ancestor of other
        '{OP_LCA,  2,    1023, 0,    0,    1'b1, 1023}, // same, operands swapped
        '{OP_LOAD, 3,    0,    1023, 0,    1'b0, 0},
        '{OP_LCA,  2,    3,    0,    0,    1'b0, 0},
        '{OP_LCA,  3,    3,    0,    0,    1'b1, 3},
        '{OP_LCA,  2,    0,    0,    0,    1'b1, 0},
        '{OP_NONE, 1023, 1023, 1023, 1023, 1'b0, 0},    // dropped, no answer
        '{OP_LOAD, 4,    0,    0,    0,    1'b0, 0},
        '{OP_LCA,  4,    2,    0,    0,    1'b1, 0},    // separate trees
        '{OP_LOAD, 3,    0,    3,    0,    1'b0, 0},    // node is its own parent
        '{OP_KTH,  3,    0,    0,    3,    1'b0, 0},
        '{OP_LOAD, 1,    0,    2,    0,    1'b0, 0},    // cycle: root moved below 2
        '{OP_KTH,  1,    0,    0,    4,    1'b0, 0},
        '{OP_LCA,  1,    2,    0,    0,    1'b0, 0}
    };

    function automatic int ancestor_at(input int n, input int lvl);
        if (n == 0 || n >= MAX_NODES || lvl >= JUMP_LEVELS)
            return 0;
        return int'(anc_tab[n][lvl]);
    endfunction

    function automatic int depth_at(input int n);
        if (n == 0 || n >= MAX_NODES)
            return 0;
        return int'(depth_tab[n]);
    endfunction

    // Greedy walk from the top level down; leftover steps are dropped.
    function automatic int climb_by(input int u, input int k);
        for (int i = JUMP_LEVELS - 1; i >= 0; i--)
        begin
            if (k >= (1 << i))
            begin
                k -= (1 << i);
                u = ancestor_at(u, i);
            end
        end
        return u;
    endfunction

    function automatic int ancestor_by_steps(input int u, input int k);
        if (k > depth_at(u))
            return 0;
        return climb_by(u, k);
    endfunction

    function automatic int common_ancestor(input int u, input int v);
        int du;
        int dv;
        int t;
        int pu;
        int pv;
        du = depth_at(u);
        dv = depth_at(v);
        if (du < dv)
        begin
            t = u;  u = v;   v = t;
            t = du; du = dv; dv = t;
        end
        u = climb_by(u, du - dv);
        if (u == v)
            return u;
        for (int i = JUMP_LEVELS - 1; i >= 0; i--)
        begin
            pu = ancestor_at(u, i);
            pv = ancestor_at(v, i);
            if (pu != pv)
            begin
                u = pu;
                v = pv;
            end
        end
        return ancestor_at(u, 0);
    endfunction

    // Row is filled level by level in place, so self and cyclic parents see
    // the entries written just before.
    function automatic void apply_load(input int n, input int p);
        int d;
        if (n == 0 || n >= MAX_NODES)
            return;
        d = (p == 0) ? 0 : depth_at(p) + 1;
        if (d > int'(DEPTH_MAX))
            d = int'(DEPTH_MAX);
        anc_tab[n][0] = NODE_W'(p);
        for (int i = 1; i < JUMP_LEVELS; i++)
            anc_tab[n][i] = NODE_W'(ancestor_at(int'(anc_tab[n][i-1]), i - 1));
        depth_tab[n] = NODE_W'(d);
        if (!is_loaded[n])
        begin
            is_loaded[n] = 1'b1;
            loaded_ids.push_back(n);
        end
        if (d > deepest_seen)
            deepest_seen = d;
    endfunction

    function automatic int deepest_node();
        int best;
        best = 0;
        foreach (loaded_ids[i])
            if (best == 0 || depth_at(loaded_ids[i]) > depth_at(best))
                best = loaded_ids[i];
        return best;
    endfunction

    // Only the sentinel or loaded nodes are ever named, so no unwritten
    // RAM entry is used in an answer.
    function automatic int pick_node();
        if (loaded_ids.size() == 0 || $urandom_range(0, 99) < 8)
            return 0;
        return loaded_ids[$urandom_range(0, loaded_ids.size() - 1)];
    endfunction

    // Idle bursts come in stretches of differing intensity, some with none.
    function automatic bit stall_now(inout int left, inout int pct);
        if (left == 0)
        begin
            left = $urandom_range(40, 300);
            case ($urandom_range(0, 2))
                0:       pct = 0;
                1:       pct = 12;
                default: pct = 35;
            endcase
        end
        left--;
        return $urandom_range(0, 99) < pct;
    endfunction

    // ------------------------------------------------------------------
    // Sender: one transaction, driven at the falling edge, held until it is
    // accepted at a rising edge. Prediction happens at the accepting edge.
    // ------------------------------------------------------------------
    task automatic issue(input logic [OP_W-1:0] op, input int a, input int b,
                         input int p, input int k, input bit typed = 1'b0,
                         input int want = 0);
        int gap;
        @(negedge clk);
        if (!quiet_tail && stall_now(src_left, src_pct))
        begin
            gap = $urandom_range(1, 12);
            item_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid       = 1'b1;
        item_ch.op          = op;
        item_ch.node_a      = NODE_W'(a);
        item_ch.node_b      = NODE_W'(b);
        item_ch.parent_node = NODE_W'(p);
        item_ch.steps       = NODE_W'(k);
        do
            @(posedge clk);
        while (!item_ch.ready);

        case (op)
            OP_LOAD:
            begin
                loads_done++;
                apply_load(a, p);
            end
            OP_LCA:
            begin
                lca_done++;
                answers_due.push_back(typed ? want : common_ancestor(a, b));
            end
            OP_KTH:
            begin
                kth_done++;
                answers_due.push_back(typed ? want : ancestor_by_steps(a, k));
            end
            default: ignored_done++;
        endcase
    endtask

    // Random query; LCA pairs are often taken close together in load order
    // so that they share deep ancestors. Steps cluster around the depth.
    task automatic random_query();
        int ia;
        int ib;
        int a;
        int b;
        int d;
        int k;
        int n;
        n  = loaded_ids.size();
        ia = $urandom_range(0, n - 1);
        a  = ($urandom_range(0, 99) < 6) ? 0 : loaded_ids[ia];
        if ($urandom_range(0, 1) == 0)
        begin
            if ($urandom_range(0, 99) < 35)
            begin
                ib = ia + $urandom_range(0, 20) - 10;
                ib = (ib < 0) ? 0 : (ib >= n) ? n - 1 : ib;
                b  = loaded_ids[ib];
            end
            else
                b = pick_node();
            issue(OP_LCA, a, b, $urandom_range(0, 1023), $urandom_range(0, 1023));
        end
        else
        begin
            d = depth_at(a);
            case ($urandom_range(0, 3))
                0:       k = $urandom_range(0, d);
                1:       k = d;
                2:       k = (d < int'(DEPTH_MAX)) ? d + 1 : d;
                default: k = $urandom_range(0, 1023);
            endcase
            issue(OP_KTH, a, $urandom_range(0, 1023), $urandom_range(0, 1023), k);
        end
    endtask

    // Dropped transactions: unknown opcode or a load of the sentinel.
    task automatic random_noise();
        if ($urandom_range(0, 1) == 0)
            issue(OP_NONE, $urandom_range(0, 1023), $urandom_range(0, 1023),
                  $urandom_range(0, 1023), $urandom_range(0, 1023));
        else
            issue(OP_LOAD, 0, $urandom_range(0, 1023), pick_node(), $urandom_range(0, 1023));
    endtask

    // ------------------------------------------------------------------
    // Clock and timeout
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: ready changes at the falling edge. One long hold-off once
    // enough answers have come, so the engine stalls its input.
    // ------------------------------------------------------------------
    initial
    begin : sink_side
        int burst;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!long_hold_done && results_checked >= 150)
            begin
                long_hold_done  = 1'b1;
                result_ch.ready = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end
            else if (!quiet_tail && stall_now(sink_left, sink_pct))
            begin
                burst           = $urandom_range(1, 12);
                result_ch.ready = 1'b0;
                repeat (burst - 1) @(negedge clk);
            end
            else
                result_ch.ready = 1'b1;
        end
    end

    // Result checker: each accepted answer against the oldest pending one.
    always @(posedge clk)
    begin : check_results
        int due;
        if (rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            if (answers_due.size() == 0)
            begin
                $error("result_node: unexpected transaction, actual %0d",
                       result_ch.result_node);
                fail_count++;
            end
            else
            begin
                due = answers_due.pop_front();
                if (result_ch.result_node !== NODE_W'(due))
                begin
                    $error("result_node: expected %0d, actual %0d", due,
                           result_ch.result_node);
                    fail_count++;
                end
            end
            results_checked++;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int order [MAX_NODES];
        int j;
        int t;
        int prev;
        int par;
        int r;
        int back;
        int s;
        int guard;

        rst_n                = 1'b0;
        item_ch.valid        = 1'b0;
        item_ch.op           = OP_LOAD;
        item_ch.node_a       = '0;
        item_ch.node_b       = '0;
        item_ch.parent_node  = '0;
        item_ch.steps        = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // Directed table.
        foreach (plan[i])
            issue(plan[i].op, plan[i].a, plan[i].b, plan[i].par, plan[i].steps,
                  plan[i].typed, plan[i].want);

        // Grow: every node id once in shuffled order. Parents mostly extend
        // one long chain, whose tip moves only when it is extended, so depth
        // runs close to the clamp and the upper table levels get used;
        // occasional side branches and new roots hang off it.
        for (int i = 1; i < MAX_NODES; i++)
            order[i] = i;
        for (int i = MAX_NODES - 1; i > 1; i--)
        begin
            j        = $urandom_range(1, i);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        prev = 0;
        for (int i = 1; i < MAX_NODES; i++)
        begin
            r = $urandom_range(0, 999);
            if (r < 900)
                par = prev;
            else if (r < 970 && loaded_ids.size() > 0)
            begin
                back = $urandom_range(0, (loaded_ids.size() > 8) ? 7 : loaded_ids.size() - 1);
                par  = loaded_ids[loaded_ids.size() - 1 - back];
            end
            else if (r < 995)
                par = pick_node();
            else
                par = 0;
            issue(OP_LOAD, order[i], $urandom_range(0, 1023), par, $urandom_range(0, 1023));
            if (par == prev)
                prev = order[i];
            if ($urandom_range(0, 99) < 22)
                random_query();
            if ($urandom_range(0, 99) < 2)
                random_noise();
        end

        // Rewire: reload existing nodes under other nodes, themselves or no
        // parent; descendants keep their old rows.
        for (int i = 0; i < 80; i++)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                s = loaded_ids[$urandom_range(0, loaded_ids.size() - 1)];
                r = $urandom_range(0, 99);
                par = (r < 25) ? s : (r < 85) ? pick_node() : 0;
                issue(OP_LOAD, s, $urandom_range(0, 1023), par, $urandom_range(0, 1023));
            end
            else
                random_query();
        end

        // Saturate: keep reloading the deepest node under itself until its
        // depth clamps, then a few more loads past the clamp.
        s = deepest_node();
        j = 0;
        while (depth_at(s) < int'(DEPTH_MAX) || j < 3)
        begin
            if (depth_at(s) == int'(DEPTH_MAX))
                j++;
            issue(OP_LOAD, s, $urandom_range(0, 1023), s, $urandom_range(0, 1023));
            if ($urandom_range(0, 31) == 0)
                issue(OP_KTH, s, 0, 0, $urandom_range(0, 1023));
        end
        issue(OP_KTH, s, 0, 0, 1023);
        issue(OP_KTH, s, 0, 0, 1);
        issue(OP_LCA, s, pick_node(), 0, 0);

        // Tail without idling on either side.
        quiet_tail = 1'b1;
        for (int i = 0; i < TAIL_ITEMS; i++)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                s = loaded_ids[$urandom_range(0, loaded_ids.size() - 1)];
                issue(OP_LOAD, s, $urandom_range(0, 1023), pick_node(),
                      $urandom_range(0, 1023));
            end
            else
                random_query();
        end
        @(negedge clk);
        item_ch.valid = 1'b0;

        // Drain, then let a trailing load finish its walk.
        guard = 0;
        while (answers_due.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE) @(posedge clk);
        if (answers_due.size() != 0)
        begin
            $error("result_node: %0d expected transactions never arrived",
                   answers_due.size());
            fail_count++;
        end

        $display("Covered %0d loads, %0d LCA and %0d k-th ancestor queries, %0d dropped",
                 loads_done, lca_done, kth_done, ignored_done);
        $display("%0d answers checked, deepest depth %0d, %0d mismatches",
                 results_checked, deepest_seen, fail_count);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
